@@ src/kvlp_pkg.sv @@
`default_nettype none

package kvlp_pkg;

    // depth of the queue between the classifier and the parser
    localparam int QueueDepth = 4;

    // event kinds
    localparam logic [2:0] EvHeader = 3'd0;
    localparam logic [2:0] EvKey    = 3'd1;
    localparam logic [2:0] EvValue  = 3'd2;
    localparam logic [2:0] EvData   = 3'd3;
    localparam logic [2:0] EvError  = 3'd4;

    // error codes
    localparam logic [1:0] ErrNone      = 2'd0;
    localparam logic [1:0] ErrVersion   = 2'd1;
    localparam logic [1:0] ErrTruncated = 2'd2;

    // byte codes
    localparam logic [7:0] VersionByte = 8'd1;
    localparam logic [7:0] CountEscape = 8'd255;
    localparam logic [6:0] KeyEscape16 = 7'd126;
    localparam logic [6:0] KeyEscape32 = 7'd127;

    // one stream byte with its decoded properties
    typedef struct packed {
        logic [7:0] raw;
        logic       eos;
        logic       top;
        logic [6:0] low;
        logic       esc16;
        logic       esc32;
        logic       esc_ff;
        logic       is_version;
    } cls_t;

    // queue read side as seen by the parser
    typedef struct packed {
        logic valid;
        cls_t data;
    } qrd_t;

endpackage

`default_nettype wire

@@ src/kvlp_front.sv @@
`default_nettype none

module kvlp_front (
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         end_of_stream,
    input  wire logic         q_full,
    output logic              push,
    output kvlp_pkg::cls_t    cls
);
    import kvlp_pkg::*;

    // request taken whenever the queue has room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cls.raw        = data_byte;
        cls.eos        = end_of_stream;
        cls.top        = data_byte[7];
        cls.low        = data_byte[6:0];
        cls.esc16      = (data_byte[6:0] == KeyEscape16);
        cls.esc32      = (data_byte[6:0] == KeyEscape32);
        cls.esc_ff     = (data_byte == CountEscape);
        cls.is_version = (data_byte == VersionByte);
    end

endmodule

`default_nettype wire

@@ src/kvlp_queue.sv @@
`default_nettype none

module kvlp_queue #(
    parameter int DEPTH = kvlp_pkg::QueueDepth
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire kvlp_pkg::cls_t wr_data,
    output logic                full,
    input  wire logic           pop,
    output kvlp_pkg::qrd_t      rd
);
    import kvlp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // no push into a full queue, no pop from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd.valid)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ src/kvlp_back.sv @@
`default_nettype none

module kvlp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kvlp_pkg::qrd_t rd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         event_kind,
    output logic [31:0]        key_id,
    output logic [31:0]        item_count,
    output logic [6:0]         value_kind,
    output logic [31:0]        value_length,
    output logic [7:0]         payload_byte,
    output logic               value_done,
    output logic               key_done,
    output logic               record_done,
    output logic [1:0]         error_code
);
    import kvlp_pkg::*;

    typedef enum logic [10:0] {
        PH_VERSION   = 11'b000_0000_0001,
        PH_KEYCOUNT  = 11'b000_0000_0010,
        PH_KEYBYTE   = 11'b000_0000_0100,
        PH_KEY16     = 11'b000_0000_1000,
        PH_KEY32     = 11'b000_0001_0000,
        PH_COUNTBYTE = 11'b000_0010_0000,
        PH_COUNT32   = 11'b000_0100_0000,
        PH_TYPE      = 11'b000_1000_0000,
        PH_SIZEBYTE  = 11'b001_0000_0000,
        PH_SIZE32    = 11'b010_0000_0000,
        PH_DATA      = 11'b100_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbi_reg, fbi_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] keys_reg, keys_next;
    logic [31:0] vals_reg, vals_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [31:0] key_reg, key_next;
    logic [6:0]  type_reg, type_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg;
    logic [31:0] key_id_reg, count_reg, length_reg;
    logic [6:0]  vkind_reg;
    logic [7:0]  payload_reg;
    logic        vdone_reg, kdone_reg, rdone_reg;
    logic [1:0]  err_reg;

    // event under construction
    logic        have_ev;
    logic [2:0]  ev_kind;
    logic [31:0] ev_key, ev_count, ev_length;
    logic [6:0]  ev_vkind;
    logic [7:0]  ev_payload;
    logic        ev_vdone, ev_kdone, ev_rdone;
    logic [1:0]  ev_err;

    // deferred steps of the decode
    logic        do_key, single, do_count, do_size, fin_value, fin_key;
    logic [31:0] key_val, count_val, size_val;

    cls_t        b;
    logic [31:0] acc_shift;
    logic        take;

    assign b         = rd.data;
    assign acc_shift = {acc_reg[23:0], b.raw};
    assign take      = rd.valid && (!out_valid_reg || !out_stall);
    assign pop       = take;

    always_comb
    begin
        phase_next = phase_reg;
        fbi_next   = fbi_reg;
        acc_next   = acc_reg;
        keys_next  = keys_reg;
        vals_next  = vals_reg;
        bytes_next = bytes_reg;
        key_next   = key_reg;
        type_next  = type_reg;

        have_ev    = 1'b0;
        ev_kind    = EvHeader;
        ev_key     = '0;
        ev_count   = '0;
        ev_length  = '0;
        ev_vkind   = '0;
        ev_payload = '0;
        ev_vdone   = 1'b0;
        ev_kdone   = 1'b0;
        ev_rdone   = 1'b0;
        ev_err     = ErrNone;

        do_key     = 1'b0;
        single     = 1'b0;
        do_count   = 1'b0;
        do_size    = 1'b0;
        fin_value  = 1'b0;
        fin_key    = 1'b0;
        key_val    = '0;
        count_val  = '0;
        size_val   = '0;

        case (phase_reg)
            PH_KEYCOUNT:
            begin
                acc_next = acc_shift;
                if (fbi_reg == 2'd3)
                begin
                    fbi_next  = '0;
                    keys_next = acc_shift;
                    have_ev   = 1'b1;
                    ev_kind   = EvHeader;
                    ev_count  = acc_shift;
                    if (acc_shift == '0)
                    begin
                        ev_rdone   = 1'b1;
                        phase_next = PH_VERSION;
                    end
                    else
                    begin
                        phase_next = PH_KEYBYTE;
                    end
                end
                else
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
            end
            PH_KEYBYTE:
            begin
                vals_next = {31'b0, b.top};
                if (b.esc16)
                begin
                    phase_next = PH_KEY16;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
                else if (b.esc32)
                begin
                    phase_next = PH_KEY32;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    do_key  = 1'b1;
                    key_val = {25'b0, b.low};
                    single  = b.top;
                end
            end
            PH_KEY16:
            begin
                acc_next = acc_shift;
                if (fbi_reg[0])
                begin
                    fbi_next = '0;
                    do_key   = 1'b1;
                    key_val  = {16'b0, acc_shift[15:0]};
                    single   = (vals_reg == 32'd1);
                end
                else
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
            end
            PH_KEY32:
            begin
                acc_next = acc_shift;
                if (fbi_reg == 2'd3)
                begin
                    fbi_next = '0;
                    do_key   = 1'b1;
                    key_val  = acc_shift;
                    single   = (vals_reg == 32'd1);
                end
                else
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
            end
            PH_COUNTBYTE:
            begin
                if (b.esc_ff)
                begin
                    phase_next = PH_COUNT32;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    do_count  = 1'b1;
                    count_val = {24'b0, b.raw};
                end
            end
            PH_COUNT32:
            begin
                acc_next = acc_shift;
                if (fbi_reg == 2'd3)
                begin
                    fbi_next  = '0;
                    do_count  = 1'b1;
                    count_val = acc_shift;
                end
                else
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
            end
            PH_TYPE:
            begin
                type_next = b.low;
                if (b.top)
                begin
                    do_size  = 1'b1;
                    size_val = 32'd1;
                end
                else
                begin
                    phase_next = PH_SIZEBYTE;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
            end
            PH_SIZEBYTE:
            begin
                if (b.esc_ff)
                begin
                    phase_next = PH_SIZE32;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    do_size  = 1'b1;
                    size_val = {24'b0, b.raw};
                end
            end
            PH_SIZE32:
            begin
                acc_next = acc_shift;
                if (fbi_reg == 2'd3)
                begin
                    fbi_next = '0;
                    do_size  = 1'b1;
                    size_val = acc_shift;
                end
                else
                begin
                    fbi_next = fbi_reg + 1'b1;
                end
            end
            PH_DATA:
            begin
                have_ev    = 1'b1;
                ev_kind    = EvData;
                ev_key     = key_reg;
                ev_vkind   = type_reg;
                ev_payload = b.raw;
                bytes_next = bytes_reg - 1'b1;
                if (bytes_reg == 32'd1)
                begin
                    ev_vdone  = 1'b1;
                    fin_value = 1'b1;
                end
            end
            default:
            begin
                if (!b.is_version)
                begin
                    phase_next = PH_VERSION;
                    have_ev    = 1'b1;
                    ev_kind    = EvError;
                    ev_err     = ErrVersion;
                end
                else
                begin
                    phase_next = PH_KEYCOUNT;
                    fbi_next   = '0;
                    acc_next   = '0;
                end
            end
        endcase

        // key decoded: single-value keys report a count of one at once
        if (do_key)
        begin
            key_next = key_val;
            if (single)
            begin
                do_count  = 1'b1;
                count_val = 32'd1;
            end
            else
            begin
                phase_next = PH_COUNTBYTE;
                fbi_next   = '0;
                acc_next   = '0;
            end
        end

        if (do_count)
        begin
            vals_next = count_val;
            have_ev   = 1'b1;
            ev_kind   = EvKey;
            ev_key    = key_next;
            ev_count  = count_val;
            if (count_val == '0)
            begin
                ev_kdone = 1'b1;
                fin_key  = 1'b1;
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end

        if (do_size)
        begin
            bytes_next = size_val;
            have_ev    = 1'b1;
            ev_kind    = EvValue;
            ev_key     = key_reg;
            ev_vkind   = type_next;
            ev_length  = size_val;
            if (size_val == '0)
            begin
                ev_vdone  = 1'b1;
                fin_value = 1'b1;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end

        // completion cascades value -> key -> record
        if (fin_value)
        begin
            vals_next = vals_reg - 1'b1;
            if (vals_reg == 32'd1)
            begin
                ev_kdone = 1'b1;
                fin_key  = 1'b1;
            end
            else
            begin
                phase_next = PH_TYPE;
            end
        end

        if (fin_key)
        begin
            keys_next = keys_reg - 1'b1;
            if (keys_reg == 32'd1)
            begin
                ev_rdone   = 1'b1;
                phase_next = PH_VERSION;
            end
            else
            begin
                phase_next = PH_KEYBYTE;
            end
        end

        // stream ends inside a record: drop everything, report truncation
        if (b.eos && (phase_next != PH_VERSION))
        begin
            phase_next = PH_VERSION;
            fbi_next   = '0;
            acc_next   = '0;
            keys_next  = '0;
            vals_next  = '0;
            bytes_next = '0;
            key_next   = '0;
            type_next  = '0;
            have_ev    = 1'b1;
            ev_kind    = EvError;
            ev_key     = '0;
            ev_count   = '0;
            ev_length  = '0;
            ev_vkind   = '0;
            ev_payload = '0;
            ev_vdone   = 1'b0;
            ev_kdone   = 1'b0;
            ev_rdone   = 1'b0;
            ev_err     = ErrTruncated;
        end
    end

    always_comb
    begin
        if (take && have_ev)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_VERSION;
            fbi_reg       <= '0;
            acc_reg       <= '0;
            keys_reg      <= '0;
            vals_reg      <= '0;
            bytes_reg     <= '0;
            key_reg       <= '0;
            type_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                fbi_reg   <= fbi_next;
                acc_reg   <= acc_next;
                keys_reg  <= keys_next;
                vals_reg  <= vals_next;
                bytes_reg <= bytes_next;
                key_reg   <= key_next;
                type_reg  <= type_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && have_ev)
        begin
            kind_reg    <= ev_kind;
            key_id_reg  <= ev_key;
            count_reg   <= ev_count;
            vkind_reg   <= ev_vkind;
            length_reg  <= ev_length;
            payload_reg <= ev_payload;
            vdone_reg   <= ev_vdone;
            kdone_reg   <= ev_kdone;
            rdone_reg   <= ev_rdone;
            err_reg     <= ev_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign key_id       = key_id_reg;
    assign item_count   = count_reg;
    assign value_kind   = vkind_reg;
    assign value_length = length_reg;
    assign payload_byte = payload_reg;
    assign value_done   = vdone_reg;
    assign key_done     = kdone_reg;
    assign record_done  = rdone_reg;
    assign error_code   = err_reg;

    // a finished record always leaves the parser waiting for a version byte
    a_record_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && have_ev && ev_rdone) |=> (phase_reg == PH_VERSION))
        else $error("record done but parser not back at version");

    // truncation clears the running counts
    a_trunc_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && have_ev && (ev_err == ErrTruncated))
            |=> (phase_reg == PH_VERSION) && (keys_reg == '0) && (fbi_reg == '0))
        else $error("truncation left state behind");

    // partial field bytes only exist inside a multi-byte field
    a_fbi_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (fbi_reg != '0) |-> ((phase_reg == PH_KEYCOUNT) || (phase_reg == PH_KEY16)
            || (phase_reg == PH_KEY32) || (phase_reg == PH_COUNT32)
            || (phase_reg == PH_SIZE32)))
        else $error("field byte index outside multi-byte field");

endmodule

`default_nettype wire

@@ src/keyed_value_list_parser_core.sv @@
`default_nettype none

// channel   direction  handshake              payload
// input     in         in_valid / in_stall    data_byte, end_of_stream
// output    out        out_valid / out_stall  event_kind .. error_code
//
// one stream byte is accepted per cycle while the queue has room; the
// parser retires one queued byte per cycle whenever the output register is
// free or being taken, so the sustained rate is one byte per clock
// an event's byte is written into the queue on the edge that accepts it, and
// the parser step from the queue head then loads the event output register
// rst_n clears the queue, the parse state and the output valid at once
// in_stall rises only when the queue is full; out_stall holds the event
// register and, once the queue fills, backs up into in_stall
module keyed_value_list_parser_core #(
    parameter int QUEUE_DEPTH = kvlp_pkg::QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input requests
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_stream,
    // output events
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_kind,
    output logic [31:0]      key_id,
    output logic [31:0]      item_count,
    output logic [6:0]       value_kind,
    output logic [31:0]      value_length,
    output logic [7:0]       payload_byte,
    output logic             value_done,
    output logic             key_done,
    output logic             record_done,
    output logic [1:0]       error_code
);
    import kvlp_pkg::*;

    // front side: classify the byte and push it into the queue
    cls_t front_cls;
    logic front_push;
    logic q_full;
    qrd_t q_rd;
    logic q_pop;

    kvlp_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .q_full        (q_full),
        .push          (front_push),
        .cls           (front_cls)
    );

    // short queue decouples the request side from the event side
    kvlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_cls),
        .full    (q_full),
        .pop     (q_pop),
        .rd      (q_rd)
    );

    // back side: record parser with its registered event output
    kvlp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd           (q_rd),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .key_id       (key_id),
        .item_count   (item_count),
        .value_kind   (value_kind),
        .value_length (value_length),
        .payload_byte (payload_byte),
        .value_done   (value_done),
        .key_done     (key_done),
        .record_done  (record_done),
        .error_code   (error_code)
    );

endmodule

`default_nettype wire
